### rtl/adpt_pkg.sv
// Package with the shared types, codes and constants of the adaptive dark-pixel threshold block.
`default_nettype none

package adpt_pkg;

    localparam int unsigned LEVEL_W    = 8;
    localparam int unsigned COUNT_W    = 21;
    localparam int unsigned SUM_W      = 28;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [COUNT_W-1:0] MAX_PIXELS = COUNT_W'(1048576);

    localparam int unsigned DIV3_MUL   = 683;
    localparam int unsigned DIV3_SHIFT = 11;
    localparam int unsigned CHSUM_W    = LEVEL_W + 2;
    localparam int unsigned PROD_W     = 20;

    localparam int unsigned DIV_STEPS  = LEVEL_W;
    localparam int unsigned STEP_W     = $clog2(DIV_STEPS);

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] REQ_ACC = 2'd0;
    localparam logic [1:0] REQ_FIN = 2'd1;
    localparam logic [1:0] REQ_CLS = 2'd2;

    localparam logic KIND_STATS = 1'b0;
    localparam logic KIND_MASK  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_DARK_LIMIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GRAY_SET   = CFG_IDX_W'(1);

    typedef struct packed {
        logic [1:0]         req_type;
        logic [LEVEL_W-1:0] blue_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] red_level;
    } t_in_item;

    typedef struct packed {
        logic               result_kind;
        logic               mask_black;
        logic [LEVEL_W-1:0] mean_out;
        logic [COUNT_W-1:0] count_out;
    } t_out_item;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [LEVEL_W-1:0] gray;
    } t_cmd;

    typedef struct packed {
        logic               valid;
        t_cmd               cmd;
    } t_push;

    typedef struct packed {
        logic [LEVEL_W-1:0] dark_limit;
        logic [LEVEL_W-1:0] gray_set;
    } t_cfg;

endpackage

`default_nettype wire

### rtl/adpt_front.sv
// Front end: accepts items, works out the gray level and drops unused request codes.
`default_nettype none

module adpt_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire adpt_pkg::t_in_item i_in_data,
    input  wire logic              i_queue_full,
    output adpt_pkg::t_push        o_push
);

    logic                            r_valid;
    logic                            n_valid;
    adpt_pkg::t_cmd                  r_cmd;
    logic                            accept;
    logic                            known_req;
    logic [adpt_pkg::CHSUM_W-1:0]    chan_sum;
    logic [adpt_pkg::PROD_W-1:0]     prod;

    assign o_in_stall = r_valid && i_queue_full;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        unique case (i_in_data.req_type) inside
            adpt_pkg::REQ_ACC, adpt_pkg::REQ_FIN, adpt_pkg::REQ_CLS: known_req = 1'b1;
            default: known_req = 1'b0;
        endcase
    end

    assign chan_sum = adpt_pkg::CHSUM_W'(i_in_data.blue_level)
                    + adpt_pkg::CHSUM_W'(i_in_data.green_level)
                    + adpt_pkg::CHSUM_W'(i_in_data.red_level);
    assign prod = adpt_pkg::PROD_W'(chan_sum) * adpt_pkg::PROD_W'(adpt_pkg::DIV3_MUL);

    assign n_valid = o_in_stall ? 1'b1 : (accept && known_req);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.req_type <= i_in_data.req_type;
            r_cmd.gray     <= prod[adpt_pkg::DIV3_SHIFT +: adpt_pkg::LEVEL_W];
        end
    end

    assign o_push.valid = r_valid && !i_queue_full;
    assign o_push.cmd   = r_cmd;

endmodule

`default_nettype wire

### rtl/adpt_queue.sv
// Two-entry queue that decouples the front end from the back end.
`default_nettype none

module adpt_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire adpt_pkg::t_push i_push,
    output logic                 o_full,
    output logic                 o_valid,
    output adpt_pkg::t_cmd       o_cmd,
    input  wire logic            i_pop
);

    adpt_pkg::t_cmd                r_mem [adpt_pkg::QUEUE_DEPTH];
    logic [adpt_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [adpt_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [adpt_pkg::QCNT_W-1:0]   r_count;
    logic                          do_push;
    logic                          do_pop;

    assign o_full  = (r_count == adpt_pkg::QCNT_W'(adpt_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

endmodule

`default_nettype wire

### rtl/adpt_back.sv
// Back end: dark-pixel statistics, bit-serial mean division, classification and result register.
`default_nettype none

module adpt_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire adpt_pkg::t_cfg i_cfg,
    input  wire logic           i_cmd_valid,
    input  wire adpt_pkg::t_cmd i_cmd,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output adpt_pkg::t_out_item o_out_data
);

    typedef enum logic [2:0] {
        S_RUN  = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                           r_state, n_state;
    logic [adpt_pkg::SUM_W-1:0]       r_sum, n_sum;
    logic [adpt_pkg::COUNT_W-1:0]     r_cnt, n_cnt;
    logic [adpt_pkg::LEVEL_W-1:0]     r_mean, n_mean;
    logic                             r_out_valid, n_out_valid;
    adpt_pkg::t_out_item              r_out_data, n_out_data;
    logic [adpt_pkg::COUNT_W-1:0]     r_div_den, n_div_den;
    logic [adpt_pkg::COUNT_W-1:0]     r_div_rem, n_div_rem;
    logic [adpt_pkg::LEVEL_W-1:0]     r_div_src, n_div_src;
    logic [adpt_pkg::LEVEL_W-1:0]     r_div_quo, n_div_quo;
    logic [adpt_pkg::STEP_W-1:0]      r_div_step, n_div_step;
    logic                             out_free;
    logic [adpt_pkg::COUNT_W:0]       rem_shift;
    logic                             rem_ge;
    logic                             blk;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = (r_state == S_RUN) && i_cmd_valid && out_free;

    assign rem_shift = {r_div_rem, r_div_src[adpt_pkg::LEVEL_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, r_div_den});

    // gray < dark_limit - gray_set + mean, rearranged to avoid signed values
    assign blk = ({1'b0, i_cmd.gray} + {1'b0, i_cfg.gray_set})
               < ({1'b0, i_cfg.dark_limit} + {1'b0, r_mean});

    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_mean      = r_mean;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_div_den   = r_div_den;
        n_div_rem   = r_div_rem;
        n_div_src   = r_div_src;
        n_div_quo   = r_div_quo;
        n_div_step  = r_div_step;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_RUN: begin
                if (o_pop) begin
                    case (i_cmd.req_type)
                        adpt_pkg::REQ_ACC: begin
                            if ((i_cmd.gray < i_cfg.dark_limit)
                                && (r_cnt < adpt_pkg::MAX_PIXELS)) begin
                                n_sum = r_sum + adpt_pkg::SUM_W'(i_cmd.gray);
                                n_cnt = r_cnt + 1'b1;
                            end
                        end
                        adpt_pkg::REQ_FIN: begin
                            n_sum = '0;
                            n_cnt = '0;
                            if (r_cnt == '0) begin
                                n_mean                 = '0;
                                n_out_valid            = 1'b1;
                                n_out_data.result_kind = adpt_pkg::KIND_STATS;
                                n_out_data.mask_black  = 1'b0;
                                n_out_data.mean_out    = '0;
                                n_out_data.count_out   = '0;
                            end else begin
                                n_div_den  = r_cnt;
                                n_div_rem  = adpt_pkg::COUNT_W'(
                                    r_sum[adpt_pkg::SUM_W-1:adpt_pkg::LEVEL_W]);
                                n_div_src  = r_sum[adpt_pkg::LEVEL_W-1:0];
                                n_div_quo  = '0;
                                n_div_step = '0;
                                n_state    = S_DIV;
                            end
                        end
                        adpt_pkg::REQ_CLS: begin
                            n_out_valid            = 1'b1;
                            n_out_data.result_kind = adpt_pkg::KIND_MASK;
                            n_out_data.mask_black  = blk;
                            n_out_data.mean_out    = r_mean;
                            n_out_data.count_out   = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                n_div_rem  = rem_ge ? adpt_pkg::COUNT_W'(rem_shift - {1'b0, r_div_den})
                                    : adpt_pkg::COUNT_W'(rem_shift);
                n_div_src  = {r_div_src[adpt_pkg::LEVEL_W-2:0], 1'b0};
                n_div_quo  = {r_div_quo[adpt_pkg::LEVEL_W-2:0], rem_ge};
                n_div_step = r_div_step + 1'b1;
                if (r_div_step == adpt_pkg::STEP_W'(adpt_pkg::DIV_STEPS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_mean                 = r_div_quo;
                    n_out_valid            = 1'b1;
                    n_out_data.result_kind = adpt_pkg::KIND_STATS;
                    n_out_data.mask_black  = 1'b0;
                    n_out_data.mean_out    = r_div_quo;
                    n_out_data.count_out   = r_div_den;
                    n_state                = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_mean      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
            r_mean      <= n_mean;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_div_den  <= n_div_den;
        r_div_rem  <= n_div_rem;
        r_div_src  <= n_div_src;
        r_div_quo  <= n_div_quo;
        r_div_step <= n_div_step;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

### rtl/adaptive_dark_pixel_threshold_core.sv
// Top level of the adaptive dark-pixel threshold block.
//
//   Channel   Direction  Handshake            Payload
//   in        input      i_in_valid/o_in_stall   t_in_item
//   out       output     o_out_valid/i_out_stall t_out_item
//   cfg       input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// Accumulate and classify items are taken one per cycle unless a stall or a division holds
// the flow, and the back end retires each in its run state. A finish item with dark pixels
// holds the back end to load the divider, run eight one-bit steps and report the mean.
// Reset is synchronous and active low; it clears the counters and the mean and sets
// dark_limit to 50 and gray_set to 0.
// A two-entry queue lets the front end keep taking items while the back end divides
// or waits on a stalled result.
`default_nettype none

module adaptive_dark_pixel_threshold_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire adpt_pkg::t_in_item                 i_in_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output adpt_pkg::t_out_item                     o_out_data,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [adpt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [adpt_pkg::LEVEL_W-1:0]       i_cfg_data
);

    adpt_pkg::t_cfg  r_cfg;
    adpt_pkg::t_push push;
    adpt_pkg::t_cmd  q_cmd;
    logic            q_full;
    logic            q_valid;
    logic            pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dark_limit <= adpt_pkg::LEVEL_W'(50);
            r_cfg.gray_set   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == adpt_pkg::CFG_DARK_LIMIT) begin
                r_cfg.dark_limit <= i_cfg_data;
            end else if (i_cfg_index == adpt_pkg::CFG_GRAY_SET) begin
                r_cfg.gray_set <= i_cfg_data;
            end
        end
    end

    adpt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_queue_full (q_full),
        .o_push       (push)
    );

    adpt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    adpt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

### rtl/adpt_checker.sv
// Port-level checker for the adaptive dark-pixel threshold block, with its bind statement.
`default_nettype none

module adpt_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire adpt_pkg::t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("Stalled result transfer changed or was dropped.");

    a_mask_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.result_kind == adpt_pkg::KIND_MASK)
        |-> (o_out_data.count_out == '0))
        else $error("Mask result carries a non-zero count.");

    a_stats_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.result_kind == adpt_pkg::KIND_STATS)
        |-> !o_out_data.mask_black)
        else $error("Statistics report has the black flag set.");

    a_stats_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.result_kind == adpt_pkg::KIND_STATS)
        |-> (o_out_data.count_out <= adpt_pkg::MAX_PIXELS)
            && ((o_out_data.count_out != '0) || (o_out_data.mean_out == '0)))
        else $error("Statistics report count or mean out of range.");

endmodule

bind adaptive_dark_pixel_threshold_core adpt_checker u_adpt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
